/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the gravity step block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define GPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gravity step assertion failed");

// Concurrent assertion that also holds around reset.
`define GPS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gravity step assertion failed");

`endif

/* rtl/gps_pkg.sv */
// Shared constants and types of the gravity particle step block.
// Depends on nothing; imported by the top level and its checker.
package gps_pkg;

   localparam int FIELD_BITS    = 32;
   localparam int STRENGTH_BITS = 31;
   localparam int MAG_BITS      = 32;
   localparam int D2_BITS       = 66;
   localparam int ROOT_BITS     = D2_BITS / 2;
   localparam int HALF_BITS     = D2_BITS / 2;
   localparam int DEN_BITS      = ROOT_BITS + D2_BITS;
   localparam int SIZE_BITS     = 16;

   localparam int REQ_DATA_BITS = 224;
   localparam int RSP_DATA_BITS = 128;
   localparam int RSP_USER_BITS = 1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 16'd1600;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 16'd1000;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } csr_index_type;

endpackage

/* rtl/gps_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; no package dependencies.
module gps_isqrt #(
   parameter int IN_BITS   = 66,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [IN_BITS-1:0]     in_value,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   output logic [IN_BITS/2-1:0]   out_root,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int RB = IN_BITS / 2;
   localparam int EB = RB + 2;

   logic [IN_BITS-1:0]   x_ff    [RB];
   logic [IN_BITS-1:0]   x_in    [RB];
   logic [IN_BITS-1:0]   x_src   [RB];
   logic [EB-1:0]        rem_ff  [RB];
   logic [EB-1:0]        rem_in  [RB];
   logic [EB-1:0]        rem_src [RB];
   logic [RB-1:0]        root_ff [RB];
   logic [RB-1:0]        root_in [RB];
   logic [RB-1:0]        root_src[RB];
   logic [SIDE_BITS-1:0] side_ff [RB];
   logic                 valid_ff[RB];

   always_comb begin
      x_src[0]    = in_value;
      rem_src[0]  = '0;
      root_src[0] = '0;
      for (int k = 1; k < RB; k++) begin
         x_src[k]    = x_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
      end
   end

   always_comb begin
      logic [EB-1:0] sh;
      logic [EB-1:0] trial;
      logic          ge;
      for (int k = 0; k < RB; k++) begin
         sh          = {rem_src[k][EB-3:0], x_src[k][IN_BITS-1 -: 2]};
         trial       = {root_src[k], 2'b01};
         ge          = (sh >= trial);
         rem_in[k]   = ge ? sh - trial : sh;
         root_in[k]  = {root_src[k][RB-2:0], ge};
         x_in[k]     = {x_src[k][IN_BITS-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < RB; k++) begin
            x_ff[k]    <= x_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         side_ff[0] <= in_side;
         for (int k = 1; k < RB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RB; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < RB; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[RB-1];
   assign out_root  = root_ff[RB-1];
   assign out_side  = side_ff[RB-1];

endmodule

/* rtl/gps_divider.sv */
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// A first stage flags quotients too large for the result width; no package dependencies.
module gps_divider #(
   parameter int NUM_BITS  = 95,
   parameter int DEN_BITS  = 99,
   parameter int Q_BITS    = 32,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num  [2],
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [Q_BITS-1:0]    out_quot [2],
   output logic                 out_over [2],
   output logic [SIDE_BITS-1:0] out_side
);

   localparam int CW = ((NUM_BITS > DEN_BITS + Q_BITS) ? NUM_BITS : DEN_BITS + Q_BITS) + 1;

   logic [CW-1:0]        pre_rem_ff  [2];
   logic                 pre_over_ff [2];
   logic [DEN_BITS-1:0]  pre_den_ff;
   logic [SIDE_BITS-1:0] pre_side_ff;
   logic                 pre_valid_ff;

   logic [CW-1:0]        rem_ff   [Q_BITS][2];
   logic [CW-1:0]        rem_in   [Q_BITS][2];
   logic [CW-1:0]        rem_src  [Q_BITS][2];
   logic [Q_BITS-1:0]    quot_ff  [Q_BITS][2];
   logic [Q_BITS-1:0]    quot_in  [Q_BITS][2];
   logic [Q_BITS-1:0]    quot_src [Q_BITS][2];
   logic                 over_ff  [Q_BITS][2];
   logic [DEN_BITS-1:0]  den_ff   [Q_BITS];
   logic [SIDE_BITS-1:0] side_ff  [Q_BITS];
   logic                 valid_ff [Q_BITS];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 2; j++) begin
            pre_rem_ff[j]  <= CW'(in_num[j]);
            pre_over_ff[j] <= (CW'(in_num[j]) >= (CW'(in_den) << Q_BITS));
         end
         pre_den_ff  <= in_den;
         pre_side_ff <= in_side;
      end
   end

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         rem_src[0][j]  = pre_rem_ff[j];
         quot_src[0][j] = '0;
      end
      for (int k = 1; k < Q_BITS; k++) begin
         for (int j = 0; j < 2; j++) begin
            rem_src[k][j]  = rem_ff[k-1][j];
            quot_src[k][j] = quot_ff[k-1][j];
         end
      end
   end

   always_comb begin
      logic [CW-1:0] dsh;
      logic          ge;
      for (int k = 0; k < Q_BITS; k++) begin
         dsh = (k == 0) ? (CW'(pre_den_ff) << (Q_BITS - 1 - k))
                        : (CW'(den_ff[(k == 0) ? 0 : k - 1]) << (Q_BITS - 1 - k));
         for (int j = 0; j < 2; j++) begin
            ge            = (rem_src[k][j] >= dsh);
            rem_in[k][j]  = ge ? rem_src[k][j] - dsh : rem_src[k][j];
            quot_in[k][j] = {quot_src[k][j][Q_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < Q_BITS; k++) begin
            for (int j = 0; j < 2; j++) begin
               rem_ff[k][j]  <= rem_in[k][j];
               quot_ff[k][j] <= quot_in[k][j];
            end
         end
         for (int j = 0; j < 2; j++) begin
            over_ff[0][j] <= pre_over_ff[j];
         end
         den_ff[0]  <= pre_den_ff;
         side_ff[0] <= pre_side_ff;
         for (int k = 1; k < Q_BITS; k++) begin
            for (int j = 0; j < 2; j++) begin
               over_ff[k][j] <= over_ff[k-1][j];
            end
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
         for (int k = 0; k < Q_BITS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         pre_valid_ff <= in_valid;
         valid_ff[0]  <= pre_valid_ff;
         for (int k = 1; k < Q_BITS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_side  = side_ff[Q_BITS-1];
   assign out_quot  = quot_ff[Q_BITS-1];
   assign out_over  = over_ff[Q_BITS-1];

endmodule

/* rtl/gravity_particle_step.sv */
// Top level of the gravity particle step: inverse-square pull and one Euler step.
// Depends on gps_pkg, gps_isqrt and gps_divider.
//
// Usage:
//   req channel: one word per particle/attractor pair (tdata fields, lowest first:
//   particle_x, particle_y, velocity_x, velocity_y, source_x, source_y,
//   source_strength). rsp channel: one word per request (tdata: new_x, new_y,
//   new_velocity_x, new_velocity_y; tuser: accel_saturated).
//   csr port: window_width at byte 0, window_height at byte 4; write only while idle.
//   From request accept to response valid, each word passes through, in order,
//   four set-up stages, a square root at one bit per stage, two multiply
//   stages, a divider at one quotient bit per stage plus a range check, and three
//   update stages ending in the output register.
//   Throughput: one word per cycle while the receiver takes words.
//   Reset clears every valid bit and loads the window registers with 1600 and 1000.
//   When the receiver stalls with a word held, the whole pipeline holds and
//   req_tready drops; nothing is lost or repeated.
module gravity_particle_step #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // particle_x, particle_y, velocity_x, velocity_y, source_x, source_y, source_strength
   input  logic [gps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // new_x, new_y, new_velocity_x, new_velocity_y
   output logic [gps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // accel_saturated
   output logic [gps_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gps_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [gps_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [gps_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   import gps_pkg::*;

   localparam int WIDE_A = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam int WIDE_B = (WIDE_A > SIZE_BITS + FRAC_BITS) ? WIDE_A : SIZE_BITS + FRAC_BITS;
   localparam int SW     = WIDE_B + 2;
   localparam int NMB    = STRENGTH_BITS + MAG_BITS;
   localparam int NB     = NMB + 2 * FRAC_BITS;
   localparam int MULB   = 2 * HALF_BITS;

   localparam logic signed [SW-1:0] WMAX =
      signed'({{(SW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}});
   localparam logic signed [SW-1:0] WMIN = ~WMAX;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] px;
      logic signed [FIELD_BITS-1:0] py;
      logic signed [FIELD_BITS-1:0] vx;
      logic signed [FIELD_BITS-1:0] vy;
   } kin_type;

   typedef struct packed {
      kin_type                        k;
      logic [STRENGTH_BITS-1:0]       st;
      logic signed [FIELD_BITS:0]     dx;
      logic signed [FIELD_BITS:0]     dy;
   } s1_type;

   typedef struct packed {
      kin_type                  k;
      logic [STRENGTH_BITS-1:0] st;
      logic [MAG_BITS-1:0]      mx;
      logic [MAG_BITS-1:0]      my;
      logic                     negx;
      logic                     negy;
   } s2_type;

   typedef struct packed {
      kin_type                 k;
      logic [2*MAG_BITS-1:0]   sqx;
      logic [2*MAG_BITS-1:0]   sqy;
      logic [NMB-1:0]          nmx;
      logic [NMB-1:0]          nmy;
      logic                    negx;
      logic                    negy;
   } s3_type;

   typedef struct packed {
      kin_type              k;
      logic [D2_BITS-1:0]   d2;
      logic [NMB-1:0]       nmx;
      logic [NMB-1:0]       nmy;
      logic                 negx;
      logic                 negy;
   } s4_type;

   typedef struct packed {
      kin_type              k;
      logic [NMB-1:0]       nmx;
      logic [NMB-1:0]       nmy;
      logic                 negx;
      logic                 negy;
      logic                 zero;
      logic [MULB-1:0]      plo;
      logic [MULB-1:0]      phi;
   } m1_type;

   typedef struct packed {
      kin_type              k;
      logic [NMB-1:0]       nmx;
      logic [NMB-1:0]       nmy;
      logic                 negx;
      logic                 negy;
      logic                 zero;
      logic [DEN_BITS-1:0]  den;
   } m2_type;

   typedef struct packed {
      kin_type k;
      logic    negx;
      logic    negy;
      logic    zero;
   } div_side_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] px;
      logic signed [FIELD_BITS-1:0] py;
      logic signed [SW-1:0]         nvx;
      logic signed [SW-1:0]         nvy;
      logic                         flag;
   } f1_type;

   typedef struct packed {
      logic signed [SW-1:0] npx;
      logic signed [SW-1:0] npy;
      logic signed [SW-1:0] nvx;
      logic signed [SW-1:0] nvy;
      logic                 flag;
   } f2_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] nx;
      logic [FIELD_BITS-1:0] ny;
      logic [FIELD_BITS-1:0] nvx;
      logic [FIELD_BITS-1:0] nvy;
      logic                  sat;
   } rsp_type;

   function automatic logic [SW:0] sat_word(input logic signed [SW-1:0] v);
      priority if (v > WMAX) return {1'b1, WMAX};
      else if (v < WMIN) return {1'b1, WMIN};
      else return {1'b0, v};
   endfunction

   function automatic logic [SW:0] accel_of(input logic [WORD_BITS-1:0] q,
                                            input logic over, input logic neg);
      logic [SW-1:0] qe;
      logic [SW-1:0] cap;
      qe  = SW'(q);
      cap = neg ? $unsigned(-WMIN) : $unsigned(WMAX);
      priority if (over || qe > cap) return {1'b1, neg ? WMIN : WMAX};
      else if (neg) return {1'b0, -qe};
      else return {1'b0, qe};
   endfunction

   function automatic logic [SW:0] bounce_of(input logic signed [SW-1:0] pos,
                                             input logic signed [SW-1:0] vel,
                                             input logic signed [SW-1:0] lim);
      priority if (pos > 0 && pos < lim) return {1'b0, vel};
      else if (vel == WMIN) return {1'b1, WMAX};
      else return {1'b0, -vel};
   endfunction

   // configuration registers
   logic [SIZE_BITS-1:0] width_ff;
   logic [SIZE_BITS-1:0] height_ff;
   csr_index_type        csr_index;

   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[SIZE_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
      endcase
   end

   // pipeline flow
   logic advance;
   logic out_valid_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   logic   v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      logic signed [FIELD_BITS-1:0] sx;
      logic signed [FIELD_BITS-1:0] sy;
      s1_in.k.px = req_tdata[31:0];
      s1_in.k.py = req_tdata[63:32];
      s1_in.k.vx = req_tdata[95:64];
      s1_in.k.vy = req_tdata[127:96];
      sx         = req_tdata[159:128];
      sy         = req_tdata[191:160];
      s1_in.st   = req_tdata[222:192];
      s1_in.dx   = (FIELD_BITS + 1)'(sx) - (FIELD_BITS + 1)'(s1_in.k.px);
      s1_in.dy   = (FIELD_BITS + 1)'(sy) - (FIELD_BITS + 1)'(s1_in.k.py);
   end

   always_comb begin
      s2_in.k    = s1_ff.k;
      s2_in.st   = s1_ff.st;
      s2_in.negx = s1_ff.dx[FIELD_BITS];
      s2_in.negy = s1_ff.dy[FIELD_BITS];
      s2_in.mx   = MAG_BITS'(s1_ff.dx[FIELD_BITS] ? -s1_ff.dx : s1_ff.dx);
      s2_in.my   = MAG_BITS'(s1_ff.dy[FIELD_BITS] ? -s1_ff.dy : s1_ff.dy);
   end

   always_comb begin
      s3_in.k    = s2_ff.k;
      s3_in.negx = s2_ff.negx;
      s3_in.negy = s2_ff.negy;
      s3_in.sqx  = (2 * MAG_BITS)'(s2_ff.mx) * (2 * MAG_BITS)'(s2_ff.mx);
      s3_in.sqy  = (2 * MAG_BITS)'(s2_ff.my) * (2 * MAG_BITS)'(s2_ff.my);
      s3_in.nmx  = NMB'(s2_ff.st) * NMB'(s2_ff.mx);
      s3_in.nmy  = NMB'(s2_ff.st) * NMB'(s2_ff.my);
   end

   always_comb begin
      s4_in.k    = s3_ff.k;
      s4_in.negx = s3_ff.negx;
      s4_in.negy = s3_ff.negy;
      s4_in.nmx  = s3_ff.nmx;
      s4_in.nmy  = s3_ff.nmy;
      s4_in.d2   = D2_BITS'(s3_ff.sqx) + D2_BITS'(s3_ff.sqy);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // distance
   logic                 sq_valid;
   logic [ROOT_BITS-1:0] sq_root;
   logic [$bits(s4_type)-1:0] sq_side_raw;
   s4_type               sq_side;

   gps_isqrt #(
      .IN_BITS   (D2_BITS),
      .SIDE_BITS ($bits(s4_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v4_ff),
      .in_value  (s4_ff.d2),
      .in_side   (s4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_raw)
   );

   assign sq_side = s4_type'(sq_side_raw);

   m1_type m1_in, m1_ff;
   m2_type m2_in, m2_ff;
   logic   vm1_ff, vm2_ff;

   always_comb begin
      m1_in.k    = sq_side.k;
      m1_in.nmx  = sq_side.nmx;
      m1_in.nmy  = sq_side.nmy;
      m1_in.negx = sq_side.negx;
      m1_in.negy = sq_side.negy;
      m1_in.zero = (sq_side.d2 == '0);
      m1_in.plo  = MULB'(sq_root) * MULB'(sq_side.d2[HALF_BITS-1:0]);
      m1_in.phi  = MULB'(sq_root) * MULB'(sq_side.d2[D2_BITS-1:HALF_BITS]);
   end

   always_comb begin
      m2_in.k    = m1_ff.k;
      m2_in.nmx  = m1_ff.nmx;
      m2_in.nmy  = m1_ff.nmy;
      m2_in.negx = m1_ff.negx;
      m2_in.negy = m1_ff.negy;
      m2_in.zero = m1_ff.zero;
      m2_in.den  = DEN_BITS'(m1_ff.plo) + (DEN_BITS'(m1_ff.phi) << HALF_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm1_ff <= 1'b0;
         vm2_ff <= 1'b0;
      end else if (advance) begin
         vm1_ff <= sq_valid;
         vm2_ff <= vm1_ff;
      end
   end

   // acceleration quotients
   logic [NB-1:0]        div_num [2];
   div_side_type         div_in_side;
   logic                 dv_valid;
   logic [WORD_BITS-1:0] dv_quot [2];
   logic                 dv_over [2];
   logic [$bits(div_side_type)-1:0] dv_side_raw;
   div_side_type         dv_side;

   assign div_num[0]       = NB'(m2_ff.nmx) << (2 * FRAC_BITS);
   assign div_num[1]       = NB'(m2_ff.nmy) << (2 * FRAC_BITS);
   assign div_in_side.k    = m2_ff.k;
   assign div_in_side.negx = m2_ff.negx;
   assign div_in_side.negy = m2_ff.negy;
   assign div_in_side.zero = m2_ff.zero;

   gps_divider #(
      .NUM_BITS  (NB),
      .DEN_BITS  (DEN_BITS),
      .Q_BITS    (WORD_BITS),
      .SIDE_BITS ($bits(div_side_type))
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vm2_ff),
      .in_num    (div_num),
      .in_den    (m2_ff.den),
      .in_side   (div_in_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_over  (dv_over),
      .out_side  (dv_side_raw)
   );

   assign dv_side = div_side_type'(dv_side_raw);

   // velocity, position and bounce
   f1_type  f1_in, f1_ff;
   f2_type  f2_in, f2_ff;
   rsp_type rsp_in, rsp_ff;
   logic    vf1_ff, vf2_ff;

   always_comb begin
      logic [SW:0] ax;
      logic [SW:0] ay;
      logic [SW:0] sx;
      logic [SW:0] sy;
      ax = dv_side.zero ? '0 : accel_of(dv_quot[0], dv_over[0], dv_side.negx);
      ay = dv_side.zero ? '0 : accel_of(dv_quot[1], dv_over[1], dv_side.negy);
      sx = sat_word(SW'(dv_side.k.vx) + signed'(ax[SW-1:0]));
      sy = sat_word(SW'(dv_side.k.vy) + signed'(ay[SW-1:0]));
      f1_in.px   = dv_side.k.px;
      f1_in.py   = dv_side.k.py;
      f1_in.nvx  = signed'(sx[SW-1:0]);
      f1_in.nvy  = signed'(sy[SW-1:0]);
      f1_in.flag = ax[SW] | ay[SW] | sx[SW] | sy[SW];
   end

   always_comb begin
      logic [SW:0] px;
      logic [SW:0] py;
      px = sat_word(SW'(f1_ff.px) + f1_ff.nvx);
      py = sat_word(SW'(f1_ff.py) + f1_ff.nvy);
      f2_in.npx  = signed'(px[SW-1:0]);
      f2_in.npy  = signed'(py[SW-1:0]);
      f2_in.nvx  = f1_ff.nvx;
      f2_in.nvy  = f1_ff.nvy;
      f2_in.flag = f1_ff.flag | px[SW] | py[SW];
   end

   always_comb begin
      logic signed [SW-1:0] lim_x;
      logic signed [SW-1:0] lim_y;
      logic [SW:0]          bx;
      logic [SW:0]          by;
      lim_x = signed'(SW'({width_ff, {FRAC_BITS{1'b0}}}));
      lim_y = signed'(SW'({height_ff, {FRAC_BITS{1'b0}}}));
      bx    = bounce_of(f2_ff.npx, f2_ff.nvx, lim_x);
      by    = bounce_of(f2_ff.npy, f2_ff.nvy, lim_y);
      rsp_in.nx  = f2_ff.npx[FIELD_BITS-1:0];
      rsp_in.ny  = f2_ff.npy[FIELD_BITS-1:0];
      rsp_in.nvx = bx[FIELD_BITS-1:0];
      rsp_in.nvy = by[FIELD_BITS-1:0];
      rsp_in.sat = f2_ff.flag | bx[SW] | by[SW];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff  <= f1_in;
         f2_ff  <= f2_in;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf1_ff       <= 1'b0;
         vf2_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vf1_ff       <= dv_valid;
         vf2_ff       <= vf1_ff;
         out_valid_ff <= vf2_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rsp_ff.nvy, rsp_ff.nvx, rsp_ff.ny, rsp_ff.nx};
   assign rsp_tuser  = rsp_ff.sat;

endmodule

/* rtl/gps_checker.sv */
// Port-level checker for the gravity particle step, bound to the top level.
// Depends on gps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [gps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [gps_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [gps_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [gps_pkg::CSR_DATA_BITS-1:0]  csr_prdata
);

   import gps_pkg::*;

   `GPS_ASSERT(rsp_held_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `GPS_ASSERT(rsp_held_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `GPS_ASSERT(req_ready_follows_rsp, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   `GPS_ASSERT(width_readback, clock, reset, !$past(reset) && $past(csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) && !csr_paddr[2] |-> csr_prdata[15:0] == $past(csr_pwdata[15:0]))
   `GPS_ASSERT_ALWAYS(empty_after_reset, clock, $fell(reset) |-> !rsp_tvalid)

endmodule

bind gravity_particle_step gps_checker u_gps_checker (.*);
